// ----- rtl/slcp_pkg.sv -----
// ----------------------------------------------------------------------------
// slcp_pkg
// Shared types and character constants for the serial line command parser.
// ----------------------------------------------------------------------------
package slcp_pkg;

    // event codes carried on the result channel
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_FORWARD   = 3'd1,
        EV_STATUS    = 3'd2,
        EV_SET_HIGH  = 3'd3,
        EV_SET_LOW   = 3'd4,
        EV_SET_LANG  = 3'd5
    } t_event_code;

    // received byte held between the input register and the parser
    typedef struct packed {
        logic       valid;
        logic [7:0] rx_byte;
    } t_rx_stage;

    localparam int unsigned PARAM_W   = 10;
    localparam int unsigned DIGIT_W   = 16;
    localparam logic [PARAM_W-1:0] PARAM_MAX = 10'd1023;

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UP_F  = 8'h46;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_H  = 8'h48;
    localparam logic [7:0] CH_UP_L  = 8'h4C;
    localparam logic [7:0] CH_UP_I  = 8'h49;
    localparam logic [7:0] CASE_BIT = 8'h20;

endpackage

// ----- rtl/slcp_if.sv -----
// ----------------------------------------------------------------------------
// slcp_if
// Valid/ready channels of the serial line command parser: received bytes in,
// decoded line events out.
// ----------------------------------------------------------------------------
interface slcp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface slcp_ev_if;
    logic       valid;
    logic       ready;
    logic [2:0] event_code;
    logic [9:0] param_value;

    modport source (output valid, output event_code, output param_value, input ready);
    modport sink (input valid, input event_code, input param_value, output ready);
endinterface

// ----- rtl/slcp_input_stage.sv -----
// ----------------------------------------------------------------------------
// slcp_input_stage
// Input register for received bytes; refills in the cycle the parser takes
// the held item.
// ----------------------------------------------------------------------------
module slcp_input_stage
    import slcp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    slcp_rx_if.sink     i_rx,
    input  logic        i_advance,
    output t_rx_stage   o_stage
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       accept;

    // room when empty or when the held item moves on this cycle
    assign i_rx.ready = !r_valid || i_advance;
    assign accept     = i_rx.valid && i_rx.ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // byte register
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.rx_byte = r_byte;

endmodule

// ----- rtl/slcp_line_parser.sv -----
// ----------------------------------------------------------------------------
// slcp_line_parser
// Per-line state (first byte, byte count, leading decimal value), command
// decode at end of line and the result register.
// ----------------------------------------------------------------------------
module slcp_line_parser
    import slcp_pkg::*;
#(
    parameter int unsigned LINE_BUFFER_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_rx_stage   i_stage,
    output logic        o_advance,
    slcp_ev_if.source   o_ev
);

    localparam int unsigned CNT_W = $clog2(LINE_BUFFER_SIZE);
    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_BUFFER_SIZE - 1);

    logic [7:0]         r_first_char, n_first_char;
    logic [CNT_W-1:0]   r_stored_count, n_stored_count;
    logic [DIGIT_W-1:0] r_digit_value, n_digit_value;
    logic               r_digits_ended, n_digits_ended;
    logic [PARAM_W-1:0] r_held_param, n_held_param;
    logic               r_out_valid, n_out_valid;
    t_event_code        r_out_event, n_out_event;
    logic [PARAM_W-1:0] r_out_param, n_out_param;

    logic [7:0]         b;
    logic               is_eol;
    logic               is_digit;
    logic               has_arg;
    logic               emit;
    logic [7:0]         digit_off;
    logic [DIGIT_W-1:0] digit_next;
    logic [PARAM_W-1:0] clamp_hl;
    logic [PARAM_W-1:0] clamp_lang;
    t_event_code        ev;

    // item moves on when the result register is free or being drained
    assign o_advance = i_stage.valid && (!r_out_valid || o_ev.ready);

    assign b         = i_stage.rx_byte;
    assign is_eol    = (b == CH_LF) || (b == CH_CR);
    assign is_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    assign has_arg   = r_stored_count > CNT_W'(1);
    assign emit      = is_eol && (r_stored_count != '0);
    assign digit_off = b - CH_ZERO;

    // value * 10 + digit, wrapping at 16 bits
    assign digit_next = (r_digit_value << 3) + (r_digit_value << 1)
                        + DIGIT_W'(digit_off[3:0]);

    assign clamp_hl   = (r_digit_value > DIGIT_W'(PARAM_MAX)) ? PARAM_MAX
                                                               : r_digit_value[PARAM_W-1:0];
    assign clamp_lang = (r_digit_value > DIGIT_W'(1)) ? '0 : r_digit_value[PARAM_W-1:0];

    // command decode, letter in either case
    always_comb begin
        ev = EV_NONE;
        if (r_first_char == CH_UP_F || r_first_char == (CH_UP_F | CASE_BIT)) begin
            ev = EV_FORWARD;
        end else if (r_first_char == CH_UP_A || r_first_char == (CH_UP_A | CASE_BIT)) begin
            ev = EV_STATUS;
        end else if (has_arg && (r_first_char == CH_UP_H
                     || r_first_char == (CH_UP_H | CASE_BIT))) begin
            ev = EV_SET_HIGH;
        end else if (has_arg && (r_first_char == CH_UP_L
                     || r_first_char == (CH_UP_L | CASE_BIT))) begin
            ev = EV_SET_LOW;
        end else if (has_arg && (r_first_char == CH_UP_I
                     || r_first_char == (CH_UP_I | CASE_BIT))) begin
            ev = EV_SET_LANG;
        end
    end

    // next line state and result
    always_comb begin
        n_first_char   = r_first_char;
        n_stored_count = r_stored_count;
        n_digit_value  = r_digit_value;
        n_digits_ended = r_digits_ended;
        n_held_param   = r_held_param;
        n_out_valid    = r_out_valid && !o_ev.ready;
        n_out_event    = r_out_event;
        n_out_param    = r_out_param;
        if (o_advance) begin
            if (is_eol) begin
                n_first_char   = '0;
                n_stored_count = '0;
                n_digit_value  = '0;
                n_digits_ended = 1'b0;
                n_out_valid    = emit;
                if (emit) begin
                    unique case (ev)
                        EV_SET_HIGH, EV_SET_LOW: n_held_param = clamp_hl;
                        EV_SET_LANG:             n_held_param = clamp_lang;
                        default:                 n_held_param = r_held_param;
                    endcase
                    n_out_event = ev;
                    n_out_param = n_held_param;
                end
            end else begin
                n_out_valid = 1'b0;
                if (r_stored_count < CNT_LIMIT) begin
                    if (r_stored_count == '0) begin
                        n_first_char = b;
                    end else if (!r_digits_ended) begin
                        if (is_digit) begin
                            n_digit_value = digit_next;
                        end else begin
                            n_digits_ended = 1'b1;
                        end
                    end
                    n_stored_count = r_stored_count + CNT_W'(1);
                end
            end
        end
    end

    // control and line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_char   <= '0;
            r_stored_count <= '0;
            r_digit_value  <= '0;
            r_digits_ended <= 1'b0;
            r_held_param   <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_first_char   <= n_first_char;
            r_stored_count <= n_stored_count;
            r_digit_value  <= n_digit_value;
            r_digits_ended <= n_digits_ended;
            r_held_param   <= n_held_param;
            r_out_valid    <= n_out_valid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_out_event <= n_out_event;
        r_out_param <= n_out_param;
    end

    assign o_ev.valid       = r_out_valid;
    assign o_ev.event_code  = r_out_event;
    assign o_ev.param_value = r_out_param;

endmodule

// ----- rtl/serial_line_command_parser.sv -----
// ----------------------------------------------------------------------------
// serial_line_command_parser
// Decodes command lines from a received byte stream.
//
// i_rx carries one received byte per item; o_ev carries one item per
// non-empty line (at CR or LF): an event code and the held parameter value.
// F/f forward, A/a status, H/h and L/l with an argument set the parameter
// (clamped to 1023), I/i with an argument sets the language value; any other
// line reports no event. Bytes past LINE_BUFFER_SIZE-1 in a line are dropped.
//
// A line end passes through the input register and then the result register
// before it shows on o_ev. Throughput: one byte per cycle while o_ev does not
// stall a result, with the single input register and the single result
// register; the digit accumulator is a shift-and-add by ten.
// Reset clears the line state and the held parameter to zero.
// While the receiver stalls a result, the input register takes one more
// byte, then i_rx.ready drops until o_ev drains.
// ----------------------------------------------------------------------------
module serial_line_command_parser
    import slcp_pkg::*;
#(
    parameter int unsigned LINE_BUFFER_SIZE = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    slcp_rx_if.sink     i_rx,
    slcp_ev_if.source   o_ev
);

    t_rx_stage stage;
    logic      advance;

    // byte input register
    slcp_input_stage u_input_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_stage   (stage)
    );

    // line state, decode and result register
    slcp_line_parser #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_line_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage   (stage),
        .o_advance (advance),
        .o_ev      (o_ev)
    );

endmodule
